[rtl/pfa_pkg.sv]
// shared opcode and status codes of the page frame allocator
package pfa_pkg;

  localparam int unsigned OPC_BITS    = 4;
  localparam int unsigned STATUS_BITS = 3;

  typedef enum logic [OPC_BITS-1:0] {
    OP_ALLOC       = 4'd0,
    OP_REF         = 4'd1,
    OP_DEREF       = 4'd2,
    OP_COUNT       = 4'd3,
    OP_LRU_FIRST   = 4'd4,
    OP_LRU_NEXT    = 4'd5,
    OP_LRU_REMOVE  = 4'd6,
    OP_LRU_APPEND  = 4'd7,
    OP_SET_RMAP    = 4'd8,
    OP_GET_RMAP    = 4'd9
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 3'd0,
    ST_FREE = 3'd1,
    ST_ZERO = 3'd2,
    ST_BAD  = 3'd3,
    ST_SAT  = 3'd4
  } status_e;

endpackage

[rtl/pfa_if.sv]
// request and response channel interfaces of the page frame allocator
interface pfa_req_if #(
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned RMAP_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [pfa_pkg::OPC_BITS-1:0]  opcode;
  logic [PAGE_BITS-1:0]          page;
  logic                          user_page;
  logic                          tail_move;
  logic [RMAP_BITS-1:0]          rmap_value;

  modport source (output valid, opcode, page, user_page, tail_move, rmap_value,
                  input ready);
  modport sink   (input valid, opcode, page, user_page, tail_move, rmap_value,
                  output ready);
endinterface

interface pfa_rsp_if #(
  parameter int unsigned PAGE_BITS  = 12,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned RMAP_BITS  = 32
);
  logic                             valid;
  logic                             ready;
  logic [PAGE_BITS-1:0]             page_out;
  logic [COUNT_BITS-1:0]            ref_count_out;
  logic                             in_use;
  logic [RMAP_BITS-1:0]             rmap_out;
  logic [PAGE_BITS-1:0]             available_out;
  logic [pfa_pkg::STATUS_BITS-1:0]  status;

  modport source (output valid, page_out, ref_count_out, in_use, rmap_out, available_out,
                  status, input ready);
  modport sink   (input valid, page_out, ref_count_out, in_use, rmap_out, available_out,
                  status, output ready);
endinterface

[rtl/pfa_ram.sv]
// generic simple dual port ram with registered read
module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/page_frame_allocator_lru.sv]
// page frame allocator with free list and lru list of user pages
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+---------------------------------------------
//  req_i   | in  | valid / ready | opcode, page, user_page, tail_move,
//          |     |               | rmap_value
//  rsp_o   | out | valid / ready | page_out, ref_count_out, in_use, rmap_out,
//          |     |               | available_out, status
//
// one request at a time: accept, lookup, 8 phases, a read-modify-write per neighbor
// (up to 4) and a response load, which waits while the output register is full;
// the steps are serialized by the single read port of the page table memory
// after reset a clearing pass over all PAGE_COUNT entries builds the free chain; no
// request is taken during it
// a finished word waits in the output register while the next request is taken
module page_frame_allocator_lru #(
  parameter int unsigned PAGE_COUNT = 4096,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned RMAP_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfa_req_if.sink   req_i,
  pfa_rsp_if.source rsp_o
);
  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam logic [PW-1:0] LAST_PG = PW'(PAGE_COUNT - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // one page table entry: count, marks and list links
  typedef struct packed {
    logic [COUNT_BITS-1:0] rc;
    logic                  act;
    logic                  lru;
    logic [PW-1:0]         nxt;
    logic [PW-1:0]         prv;
  } rec_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_RUN, S_FIX, S_RESP
  } state_e;

  // fixed order of list and count steps of one request
  typedef enum logic [2:0] {
    PH_UA_Q, PH_UA_N, PH_AA_T, PH_BUMP, PH_UB_Q, PH_UB_N, PH_AB_T, PH_WB
  } phase_e;

  typedef enum logic [1:0] {FX_NXT, FX_PRV, FX_INC} fix_e;
  typedef enum logic [1:0] {D_NONE, D_SELF, D_NEXT} desc_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [PW-1:0]      clr_q;
  pfa_pkg::opcode_e   op_q;
  logic               bad_q, user_q, mv_q;
  logic [RMAP_BITS-1:0] rv_q;
  logic [PW-1:0]      pg_q, npg_q, pout_q;
  rec_t               rec_q, nrec_q;
  pfa_pkg::status_e   st_q;
  desc_e              desc_q;
  logic [RMAP_BITS-1:0] rout_q, rmap_wval_q;
  logic               ua_q, ua_free_q, aa_q, bump_q, ub_q, ab_q, wr_q, rmap_wr_q;
  logic [PW-1:0]      fh_q, ft_q, lh_q, lt_q, fc_q;
  logic [PW-1:0]      fx_addr_q, fx_val_q;
  fix_e               fx_kind_q;

  // output register
  logic               ov_q;
  logic [PW-1:0]      o_page_q, o_avail_q;
  logic [COUNT_BITS-1:0] o_rc_q;
  logic               o_use_q;
  logic [RMAP_BITS-1:0] o_rmap_q;
  pfa_pkg::status_e   o_st_q;

  // memory ports
  logic               pt_we, pt_re, rm_we, rm_re;
  logic [PW-1:0]      pt_waddr, pt_raddr, rm_addr;
  rec_t               pt_wdata, pt_rdata, clr_rec, fx_rec;
  logic [RMAP_BITS-1:0] rm_rdata;

  pfa_ram #(.WIDTH($bits(rec_t)), .DEPTH(PAGE_COUNT)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  pfa_ram #(.WIDTH(RMAP_BITS), .DEPTH(PAGE_COUNT)) u_rmap_ram (
    .clk_i   (clk_i),
    .we_i    (rm_we),
    .waddr_i (pg_q),
    .wdata_i (rmap_wval_q),
    .re_i    (rm_re),
    .raddr_i (rm_addr),
    .rdata_o (rm_rdata)
  );

  // accept side
  pfa_pkg::opcode_e   in_op;
  logic               in_acc, in_pg_ok, in_needs_pg;
  logic [PW-1:0]      look_pg;

  assign in_op       = pfa_pkg::opcode_e'(req_i.opcode);
  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign in_pg_ok    = (req_i.page != '0) && (32'(req_i.page) < PAGE_COUNT);
  assign in_needs_pg = (in_op != pfa_pkg::OP_ALLOC) && (in_op != pfa_pkg::OP_LRU_FIRST) &&
                       (in_op <= pfa_pkg::OP_GET_RMAP);

  always_comb begin
    case (in_op)
      pfa_pkg::OP_ALLOC:     look_pg = fh_q;
      pfa_pkg::OP_LRU_FIRST: look_pg = lh_q;
      default:               look_pg = in_pg_ok ? req_i.page : '0;
    endcase
  end

  // initial chain entry for the clearing pass
  always_comb begin
    clr_rec     = '0;
    if (clr_q != '0) begin
      clr_rec.prv = clr_q - PW'(1);
      clr_rec.nxt = (clr_q == LAST_PG) ? '0 : clr_q + PW'(1);
    end
  end

  // decode of the looked-up page entry
  rec_t               dec_rec;
  pfa_pkg::status_e   dec_st;
  desc_e              dec_desc;
  logic               dec_ua, dec_ua_free, dec_aa, dec_bump, dec_ub, dec_ab;
  logic               dec_wr, dec_rmap_wr;
  logic [RMAP_BITS-1:0] dec_rmap_val, dec_rout;
  logic [PW-1:0]      dec_pout, dec_npg, dec_fc, lru_nxt;

  assign lru_nxt = pt_rdata.lru ? pt_rdata.nxt : '0;

  always_comb begin
    dec_rec      = pt_rdata;
    dec_st       = pfa_pkg::ST_OK;
    dec_desc     = D_SELF;
    dec_ua       = 1'b0;
    dec_ua_free  = 1'b0;
    dec_aa       = 1'b0;
    dec_bump     = 1'b0;
    dec_ub       = 1'b0;
    dec_ab       = 1'b0;
    dec_wr       = 1'b0;
    dec_rmap_wr  = 1'b0;
    dec_rmap_val = rv_q;
    dec_rout     = '0;
    dec_pout     = '0;
    dec_npg      = '0;
    dec_fc       = fc_q;
    if (bad_q) begin
      dec_st   = pfa_pkg::ST_BAD;
      dec_desc = D_NONE;
    end else begin
      case (op_q)
        pfa_pkg::OP_ALLOC: begin
          if (pg_q == '0) begin
            dec_desc = D_NONE;
          end else begin
            dec_ua       = 1'b1;
            dec_ua_free  = 1'b1;
            dec_aa       = user_q;
            dec_rec.rc   = CNT_ONE;
            dec_rec.act  = 1'b1;
            dec_rec.lru  = user_q;
            dec_wr       = 1'b1;
            dec_rmap_wr  = 1'b1;
            dec_rmap_val = '0;
            dec_pout     = pg_q;
            if (fc_q != '0) dec_fc = fc_q - PW'(1);
          end
        end
        pfa_pkg::OP_LRU_FIRST: begin
          if (pg_q == '0) begin
            dec_desc = D_NONE;
          end else begin
            if (pt_rdata.rc == CNT_MAX) dec_st = pfa_pkg::ST_SAT;
            else dec_rec.rc = pt_rdata.rc + CNT_ONE;
            dec_wr   = 1'b1;
            dec_pout = pg_q;
          end
        end
        pfa_pkg::OP_REF: begin
          if (!pt_rdata.act) begin
            dec_st = pfa_pkg::ST_FREE;
          end else if (pt_rdata.rc == CNT_MAX) begin
            dec_st = pfa_pkg::ST_SAT;
          end else begin
            dec_rec.rc = pt_rdata.rc + CNT_ONE;
            dec_wr     = 1'b1;
          end
        end
        pfa_pkg::OP_DEREF, pfa_pkg::OP_LRU_NEXT: begin
          if (pt_rdata.rc == '0) begin
            dec_st = pfa_pkg::ST_ZERO;
            if (op_q == pfa_pkg::OP_LRU_NEXT) dec_desc = D_NONE;
          end else begin
            if (op_q == pfa_pkg::OP_LRU_NEXT) begin
              // move to tail first, then bump the successor, then drop
              if (mv_q && pt_rdata.lru && (pt_rdata.rc != CNT_ONE)) begin
                dec_ua = 1'b1;
                dec_aa = 1'b1;
              end
              dec_bump = (lru_nxt != '0);
              dec_npg  = lru_nxt;
              dec_pout = lru_nxt;
              dec_desc = (lru_nxt != '0) ? D_NEXT : D_NONE;
            end
            dec_rec.rc = pt_rdata.rc - CNT_ONE;
            dec_wr     = 1'b1;
            if (pt_rdata.rc == CNT_ONE) begin
              // last reference: off the lru, onto the free tail
              dec_ub      = pt_rdata.lru;
              dec_ab      = 1'b1;
              dec_rec.act = 1'b0;
              dec_rec.lru = 1'b0;
              if (fc_q != LAST_PG) dec_fc = fc_q + PW'(1);
            end
          end
        end
        pfa_pkg::OP_COUNT: begin
          dec_wr = 1'b0;
        end
        pfa_pkg::OP_LRU_REMOVE: begin
          if (pt_rdata.lru) begin
            dec_ua      = 1'b1;
            dec_rec.lru = 1'b0;
            dec_wr      = 1'b1;
          end
        end
        pfa_pkg::OP_LRU_APPEND: begin
          if (!pt_rdata.act) begin
            dec_st = pfa_pkg::ST_FREE;
          end else begin
            dec_ua      = pt_rdata.lru;
            dec_aa      = 1'b1;
            dec_rec.lru = 1'b1;
            dec_wr      = 1'b1;
          end
        end
        pfa_pkg::OP_SET_RMAP: begin
          if (!pt_rdata.act && (rv_q != '0)) dec_st = pfa_pkg::ST_FREE;
          else dec_rmap_wr = 1'b1;
        end
        pfa_pkg::OP_GET_RMAP: begin
          if (!pt_rdata.act) dec_st = pfa_pkg::ST_FREE;
          else dec_rout = rm_rdata;
        end
        default: begin
          dec_desc = D_NONE;
        end
      endcase
    end
  end

  // list steps: register side of head and tail, and neighbor fixups
  logic               run_fix, unl_en, unl_free, app_en, app_free;
  logic [PW-1:0]      run_addr, run_val, app_tail;
  fix_e               run_kind;
  logic [PW-1:0]      fh_d, ft_d, lh_d, lt_d;
  rec_t               rec_d;

  assign unl_en   = (phase_q == PH_UA_Q || phase_q == PH_UA_N) ? ua_q : ub_q;
  assign unl_free = (phase_q == PH_UA_Q || phase_q == PH_UA_N) && ua_free_q;
  assign app_en   = (phase_q == PH_AA_T) ? aa_q : ab_q;
  assign app_free = (phase_q == PH_AB_T);
  assign app_tail = app_free ? ft_q : lt_q;

  always_comb begin
    run_fix  = 1'b0;
    run_addr = '0;
    run_val  = '0;
    run_kind = FX_NXT;
    fh_d     = fh_q;
    ft_d     = ft_q;
    lh_d     = lh_q;
    lt_d     = lt_q;
    rec_d    = rec_q;
    case (phase_q)
      PH_UA_Q, PH_UB_Q: begin
        if (unl_en) begin
          if (rec_q.prv != '0) begin
            run_fix  = 1'b1;
            run_addr = rec_q.prv;
            run_kind = FX_NXT;
            run_val  = rec_q.nxt;
          end else if (unl_free) begin
            fh_d = rec_q.nxt;
          end else begin
            lh_d = rec_q.nxt;
          end
        end
      end
      PH_UA_N, PH_UB_N: begin
        if (unl_en) begin
          if (rec_q.nxt != '0) begin
            run_fix  = 1'b1;
            run_addr = rec_q.nxt;
            run_kind = FX_PRV;
            run_val  = rec_q.prv;
          end else if (unl_free) begin
            ft_d = rec_q.prv;
          end else begin
            lt_d = rec_q.prv;
          end
          rec_d.nxt = '0;
          rec_d.prv = '0;
        end
      end
      PH_AA_T, PH_AB_T: begin
        if (app_en) begin
          if (app_tail != '0) begin
            run_fix  = 1'b1;
            run_addr = app_tail;
            run_kind = FX_NXT;
            run_val  = pg_q;
          end else if (app_free) begin
            fh_d = pg_q;
          end else begin
            lh_d = pg_q;
          end
          if (app_free) ft_d = pg_q;
          else lt_d = pg_q;
          rec_d.prv = app_tail;
          rec_d.nxt = '0;
        end
      end
      PH_BUMP: begin
        if (bump_q) begin
          run_fix  = 1'b1;
          run_addr = npg_q;
          run_kind = FX_INC;
        end
      end
      default: begin
        run_fix = 1'b0;
      end
    endcase
  end

  // neighbor entry after its modification
  logic fx_sat;
  assign fx_sat = (fx_kind_q == FX_INC) && (pt_rdata.rc == CNT_MAX);

  always_comb begin
    fx_rec = pt_rdata;
    case (fx_kind_q)
      FX_NXT:  fx_rec.nxt = fx_val_q;
      FX_PRV:  fx_rec.prv = fx_val_q;
      FX_INC:  if (!fx_sat) fx_rec.rc = pt_rdata.rc + CNT_ONE;
      default: fx_rec = pt_rdata;
    endcase
  end

  // memory port selection
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = pg_q;
    pt_wdata = rec_q;
    case (state_q)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
        pt_wdata = clr_rec;
      end
      S_FIX: begin
        pt_we    = 1'b1;
        pt_waddr = fx_addr_q;
        pt_wdata = fx_rec;
      end
      S_RUN: begin
        pt_we = (phase_q == PH_WB) && wr_q;
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  assign pt_re    = (state_q == S_IDLE) ? in_acc : ((state_q == S_RUN) && run_fix);
  assign pt_raddr = (state_q == S_IDLE) ? look_pg : run_addr;
  assign rm_re    = in_acc;
  assign rm_addr  = look_pg;
  assign rm_we    = (state_q == S_RUN) && (phase_q == PH_WB) && rmap_wr_q;

  logic out_free;
  assign out_free = !ov_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_UA_Q;
      clr_q   <= '0;
      fh_q    <= PW'(1);
      ft_q    <= LAST_PG;
      lh_q    <= '0;
      lt_q    <= '0;
      fc_q    <= LAST_PG;
      ov_q    <= 1'b0;
    end else begin
      // a word taken while the next one loads is handled in the response state
      if (ov_q && rsp_o.ready && (state_q != S_RESP)) ov_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == LAST_PG) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= in_op;
            bad_q   <= in_needs_pg && !in_pg_ok;
            user_q  <= req_i.user_page;
            mv_q    <= req_i.tail_move;
            rv_q    <= req_i.rmap_value;
            pg_q    <= look_pg;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          rec_q       <= dec_rec;
          st_q        <= dec_st;
          desc_q      <= dec_desc;
          ua_q        <= dec_ua;
          ua_free_q   <= dec_ua_free;
          aa_q        <= dec_aa;
          bump_q      <= dec_bump;
          ub_q        <= dec_ub;
          ab_q        <= dec_ab;
          wr_q        <= dec_wr;
          rmap_wr_q   <= dec_rmap_wr;
          rmap_wval_q <= dec_rmap_val;
          rout_q      <= dec_rout;
          pout_q      <= dec_pout;
          npg_q       <= dec_npg;
          fc_q        <= dec_fc;
          phase_q     <= PH_UA_Q;
          state_q     <= S_RUN;
        end
        S_RUN: begin
          fh_q  <= fh_d;
          ft_q  <= ft_d;
          lh_q  <= lh_d;
          lt_q  <= lt_d;
          rec_q <= rec_d;
          if (run_fix) begin
            fx_addr_q <= run_addr;
            fx_kind_q <= run_kind;
            fx_val_q  <= run_val;
            state_q   <= S_FIX;
          end else if (phase_q == PH_WB) begin
            state_q <= S_RESP;
          end else begin
            phase_q <= phase_e'(phase_q + 3'd1);
          end
        end
        S_FIX: begin
          if (fx_kind_q == FX_INC) begin
            nrec_q <= fx_rec;
            if (fx_sat) st_q <= pfa_pkg::ST_SAT;
          end
          phase_q <= phase_e'(phase_q + 3'd1);
          state_q <= S_RUN;
        end
        S_RESP: begin
          if (out_free) begin
            ov_q      <= 1'b1;
            o_page_q  <= pout_q;
            o_rmap_q  <= rout_q;
            o_avail_q <= fc_q;
            o_st_q    <= st_q;
            case (desc_q)
              D_SELF: begin
                o_rc_q  <= rec_q.rc;
                o_use_q <= rec_q.act;
              end
              D_NEXT: begin
                o_rc_q  <= nrec_q.rc;
                o_use_q <= nrec_q.act;
              end
              default: begin
                o_rc_q  <= '0;
                o_use_q <= 1'b0;
              end
            endcase
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.page_out      = o_page_q;
  assign rsp_o.ref_count_out = o_rc_q;
  assign rsp_o.in_use        = o_use_q;
  assign rsp_o.rmap_out      = o_rmap_q;
  assign rsp_o.available_out = o_avail_q;
  assign rsp_o.status        = o_st_q;
endmodule

[tb/tb_page_frame_allocator_lru.sv]
// self-checking testbench of the page frame allocator with lru list
module tb_page_frame_allocator_lru;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned RMAP_BITS  = 32;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  // opcodes 10..15 are not decoded by the block
  localparam logic [3:0]  OP_UNKNOWN = 4'd12;
  localparam logic [3:0]  OP_TOP     = 4'd15;

  typedef struct packed {
    logic [11:0] page_out;
    logic [15:0] ref_count_out;
    logic        in_use;
    logic [31:0] rmap_out;
    logic [11:0] available_out;
    logic [2:0]  status;
  } rsp_word_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [11:0] page;
    logic        user;
    logic        mv;
    logic [31:0] rmap;
    logic        typed;   // expected word below is written out by hand
    rsp_word_t   want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfa_req_if #(.PAGE_BITS(12), .RMAP_BITS(RMAP_BITS)) req_if ();
  pfa_rsp_if #(.PAGE_BITS(12), .COUNT_BITS(COUNT_BITS), .RMAP_BITS(RMAP_BITS)) rsp_if ();

  page_frame_allocator_lru #(
    .PAGE_COUNT(PAGE_COUNT),
    .COUNT_BITS(COUNT_BITS),
    .RMAP_BITS (RMAP_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow copy of the page table
  // ---------------------------------------------------------------------------
  logic [15:0] cnt_mem  [PAGE_COUNT];
  bit          act_mem  [PAGE_COUNT];
  bit          onl_mem  [PAGE_COUNT];
  int          nxt_mem  [PAGE_COUNT];
  int          prv_mem  [PAGE_COUNT];
  logic [31:0] rmap_mem [PAGE_COUNT];
  int          free_hd, free_tl, lru_hd, lru_tl, free_cnt;

  rsp_word_t   pending_q[$];   // words the block still owes us
  int          err_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          walk_pg = 0;    // cursor of an lru walk in progress
  int          live_pg[$];     // pages handed out recently, used as targets

  function automatic void shadow_reset();
    for (int i = 0; i < PAGE_COUNT; i++) begin
      cnt_mem[i]  = '0;
      act_mem[i]  = 1'b0;
      onl_mem[i]  = 1'b0;
      rmap_mem[i] = '0;
      nxt_mem[i]  = (i != 0 && i + 1 < PAGE_COUNT) ? i + 1 : 0;
      prv_mem[i]  = (i != 0) ? i - 1 : 0;
    end
    free_hd  = 1;
    free_tl  = PAGE_COUNT - 1;
    lru_hd   = 0;
    lru_tl   = 0;
    free_cnt = PAGE_COUNT - 1;
  endfunction

  // take p out of the lru list (lru=1) or the free list (lru=0)
  function automatic void chain_unlink(bit lru, int p);
    int n, q;
    n = nxt_mem[p];
    q = prv_mem[p];
    if (q != 0) nxt_mem[q] = n;
    else if (lru) lru_hd = n;
    else free_hd = n;
    if (n != 0) prv_mem[n] = q;
    else if (lru) lru_tl = q;
    else free_tl = q;
    nxt_mem[p] = 0;
    prv_mem[p] = 0;
  endfunction

  function automatic void chain_append(bit lru, int p);
    int t;
    t = lru ? lru_tl : free_tl;
    prv_mem[p] = t;
    nxt_mem[p] = 0;
    if (t != 0) nxt_mem[t] = p;
    else if (lru) lru_hd = p;
    else free_hd = p;
    if (lru) lru_tl = p;
    else free_tl = p;
  endfunction

  // saturating increment, returns 1 when already at the top
  function automatic bit count_up(int p);
    if (cnt_mem[p] == COUNT_MAX) return 1'b1;
    cnt_mem[p]++;
    return 1'b0;
  endfunction

  // drop one reference, last one sends the page to the free tail
  function automatic void count_down(int p);
    cnt_mem[p]--;
    if (cnt_mem[p] == 0) begin
      if (onl_mem[p]) chain_unlink(1'b1, p);
      onl_mem[p] = 1'b0;
      act_mem[p] = 1'b0;
      chain_append(1'b0, p);
      if (free_cnt < PAGE_COUNT - 1) free_cnt++;
    end
  endfunction

  function automatic rsp_word_t page_table_step(logic [3:0] op, logic [11:0] pg, logic user,
                                                logic mv, logic [31:0] rv);
    rsp_word_t r;
    int        p, n, dsc;
    r   = '0;
    p   = int'(pg);
    dsc = 0;
    r.status = pfa_pkg::ST_OK;
    if (op == pfa_pkg::OP_ALLOC) begin
      n = free_hd;
      if (n != 0) begin
        chain_unlink(1'b0, n);
        cnt_mem[n]  = 16'd1;
        act_mem[n]  = 1'b1;
        rmap_mem[n] = '0;
        onl_mem[n]  = 1'b0;
        if (user) begin
          chain_append(1'b1, n);
          onl_mem[n] = 1'b1;
        end
        if (free_cnt > 0) free_cnt--;
      end
      r.page_out = 12'(n);
      dsc = n;
    end else if (op == pfa_pkg::OP_LRU_FIRST) begin
      n = lru_hd;
      if (n != 0 && count_up(n)) r.status = pfa_pkg::ST_SAT;
      r.page_out = 12'(n);
      dsc = n;
    end else if (op <= pfa_pkg::OP_GET_RMAP && p == 0) begin
      r.status = pfa_pkg::ST_BAD;
    end else if (op == pfa_pkg::OP_REF) begin
      dsc = p;
      if (!act_mem[p]) r.status = pfa_pkg::ST_FREE;
      else if (count_up(p)) r.status = pfa_pkg::ST_SAT;
    end else if (op == pfa_pkg::OP_DEREF) begin
      dsc = p;
      if (cnt_mem[p] == 0) r.status = pfa_pkg::ST_ZERO;
      else count_down(p);
    end else if (op == pfa_pkg::OP_COUNT || op == pfa_pkg::OP_LRU_REMOVE) begin
      dsc = p;
      if (op == pfa_pkg::OP_LRU_REMOVE && onl_mem[p]) begin
        chain_unlink(1'b1, p);
        onl_mem[p] = 1'b0;
      end
    end else if (op == pfa_pkg::OP_LRU_NEXT) begin
      if (cnt_mem[p] == 0) begin
        r.status = pfa_pkg::ST_ZERO;
      end else begin
        n = onl_mem[p] ? nxt_mem[p] : 0;
        if (mv && onl_mem[p] && cnt_mem[p] > 1) begin
          chain_unlink(1'b1, p);
          chain_append(1'b1, p);
        end
        if (n != 0 && count_up(n)) r.status = pfa_pkg::ST_SAT;
        count_down(p);
        r.page_out = 12'(n);
        dsc = n;
      end
    end else if (op == pfa_pkg::OP_LRU_APPEND) begin
      dsc = p;
      if (!act_mem[p]) begin
        r.status = pfa_pkg::ST_FREE;
      end else begin
        if (onl_mem[p]) chain_unlink(1'b1, p);
        chain_append(1'b1, p);
        onl_mem[p] = 1'b1;
      end
    end else if (op == pfa_pkg::OP_SET_RMAP) begin
      dsc = p;
      if (!act_mem[p] && rv != 0) r.status = pfa_pkg::ST_FREE;
      else rmap_mem[p] = rv;
    end else if (op == pfa_pkg::OP_GET_RMAP) begin
      dsc = p;
      if (!act_mem[p]) r.status = pfa_pkg::ST_FREE;
      else r.rmap_out = rmap_mem[p];
    end
    if (dsc != 0) begin
      r.ref_count_out = cnt_mem[dsc];
      r.in_use        = act_mem[dsc];
    end
    r.available_out = 12'(free_cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.page       = '0;
    req_if.user_page  = 1'b0;
    req_if.tail_move  = 1'b0;
    req_if.rmap_value = '0;
    rsp_if.ready      = 1'b0;
  end

  // hand one word to the block; the expected answer is queued as it goes out
  task automatic send_word(logic [3:0] op, logic [11:0] pg, logic user, logic mv,
                           logic [31:0] rv, bit typed, rsp_word_t want,
                           output rsp_word_t got);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    got = page_table_step(op, pg, user, mv, rv);
    pending_q.push_back(typed ? want : got);
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.page       <= pg;
    req_if.user_page  <= user;
    req_if.tail_move  <= mv;
    req_if.rmap_value <= rv;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic send_plain(logic [3:0] op, logic [11:0] pg, logic user, logic mv,
                            logic [31:0] rv, output rsp_word_t got);
    send_word(op, pg, user, mv, rv, 1'b0, '0, got);
  endtask

  // hold the request side quiet until every answer is back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_page();
    int k;
    k = $urandom_range(99);
    if (k < 80 && live_pg.size() != 0)
      return 12'(live_pg[$urandom_range(live_pg.size() - 1)]);
    if (k < 90) return 12'($urandom_range(1, 40));
    if (k < 95) return 12'd0;
    return 12'($urandom);
  endfunction

  // one random word; mostly well-formed work on pages we handed out
  task automatic send_random();
    rsp_word_t   got;
    logic [3:0]  op;
    logic [11:0] pg;
    logic [31:0] rv;
    int          k;
    k  = $urandom_range(99);
    pg = pick_page();
    rv = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    if      (k < 16) op = pfa_pkg::OP_ALLOC;
    else if (k < 28) op = pfa_pkg::OP_REF;
    else if (k < 42) op = pfa_pkg::OP_DEREF;
    else if (k < 48) op = pfa_pkg::OP_COUNT;
    else if (k < 55) op = pfa_pkg::OP_LRU_FIRST;
    else if (k < 67) op = pfa_pkg::OP_LRU_NEXT;
    else if (k < 73) op = pfa_pkg::OP_LRU_REMOVE;
    else if (k < 81) op = pfa_pkg::OP_LRU_APPEND;
    else if (k < 89) op = pfa_pkg::OP_SET_RMAP;
    else if (k < 97) op = pfa_pkg::OP_GET_RMAP;
    else             op = 4'($urandom_range(pfa_pkg::OP_GET_RMAP + 1, OP_TOP));
    if (op == pfa_pkg::OP_LRU_NEXT && walk_pg != 0 && $urandom_range(3) != 0)
      pg = 12'(walk_pg);
    send_plain(op, pg, 1'($urandom), 1'($urandom), rv, got);
    if (op == pfa_pkg::OP_LRU_FIRST || op == pfa_pkg::OP_LRU_NEXT)
      walk_pg = int'(got.page_out);
    if (op == pfa_pkg::OP_ALLOC && got.page_out != 0) begin
      live_pg.push_back(int'(got.page_out));
      if (live_pg.size() > 48) void'(live_pg.pop_front());
    end
  endtask

  // directed rows; hand-written answers only where they are obvious
  dir_row_t dir_tab [] = '{
    '{pfa_pkg::OP_COUNT,      12'd0,    1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4095, pfa_pkg::ST_BAD}},
    '{pfa_pkg::OP_ALLOC,      12'd0,    1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd1, 16'd1, 1'b1, 32'd0, 12'd4094, pfa_pkg::ST_OK}},
    '{OP_UNKNOWN,             12'hFFF,  1'b1, 1'b1, 32'hFFFFFFFF, 1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_OK}},
    '{OP_TOP,                 12'd5,    1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_OK}},
    '{pfa_pkg::OP_REF,        12'hFFF,  1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_FREE}},
    '{pfa_pkg::OP_DEREF,      12'hFFF,  1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_ZERO}},
    '{pfa_pkg::OP_GET_RMAP,   12'hFFF,  1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_FREE}},
    '{pfa_pkg::OP_LRU_FIRST,  12'd0,    1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_OK}},
    '{pfa_pkg::OP_DEREF,      12'd0,    1'b0, 1'b0, 32'd0,        1'b1,
      '{12'd0, 16'd0, 1'b0, 32'd0, 12'd4094, pfa_pkg::ST_BAD}},
    // user pages 2 and 3 go on the lru list
    '{pfa_pkg::OP_ALLOC,      12'd0,    1'b1, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_ALLOC,      12'd0,    1'b1, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_SET_RMAP,   12'd2,    1'b0, 1'b0, 32'hFFFFFFFF, 1'b0, '0},
    '{pfa_pkg::OP_GET_RMAP,   12'd2,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_SET_RMAP,   12'd7,    1'b0, 1'b0, 32'h5A5A0001, 1'b0, '0},
    '{pfa_pkg::OP_SET_RMAP,   12'd7,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_FIRST,  12'd0,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_NEXT,   12'd2,    1'b0, 1'b1, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_APPEND, 12'd1,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_APPEND, 12'd3,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_APPEND, 12'd9,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_REMOVE, 12'd1,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_REMOVE, 12'd1,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    // off-list active page: no successor, still dereferenced
    '{pfa_pkg::OP_LRU_NEXT,   12'd1,    1'b0, 1'b1, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_LRU_NEXT,   12'd1,    1'b0, 1'b0, 32'd0,        1'b0, '0},
    '{pfa_pkg::OP_COUNT,      12'd3,    1'b0, 1'b0, 32'd0,        1'b0, '0}
  };

  initial begin
    rsp_word_t got;
    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].page, dir_tab[i].user, dir_tab[i].mv,
                dir_tab[i].rmap, dir_tab[i].typed, dir_tab[i].want, got);
    drain();

    // random traffic under four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 30) : 0;
      rcv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 30) : 0;
      for (int i = 0; i < 400; i++) begin
        send_random();
        if (ph == 0 && i == 200) drain();   // sender holds off until all answers are in
      end
      drain();
    end
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;

    // let a straggling word show up if there is one
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_word_t want, seen;
    rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen = '{rsp_if.page_out, rsp_if.ref_count_out, rsp_if.in_use, rsp_if.rmap_out,
               rsp_if.available_out, rsp_if.status};
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word %h", seen);
      end else begin
        want = pending_q.pop_front();
        if (seen !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch page %0d/%0d count %0d/%0d use %0b/%0b rmap %h/%h ",
                      "avail %0d/%0d st %0d/%0d"},
                     want.page_out, seen.page_out, want.ref_count_out, seen.ref_count_out,
                     want.in_use, seen.in_use, want.rmap_out, seen.rmap_out,
                     want.available_out, seen.available_out, want.status, seen.status);
        end
      end
    end
  end

  // watchdog, far beyond a full run even under the heaviest stalls
  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
